[hw/rtl/ars_pkg.sv]
// Shared types, codes and helpers for the adapter reset sequencer.
`timescale 1ns / 1ps

package ars_pkg;

  localparam logic [1:0] SHUTDOWN_KIND_IDLE = 2'd0;
  localparam logic       STICKY_OPER_MASK   = 1'b1;

  // Engine states, one-hot.
  typedef enum logic [7:0] {
    ST_UNKNOWN     = 8'b0000_0001,
    ST_DEAD        = 8'b0000_0010,
    ST_BRINGDOWN   = 8'b0000_0100,
    ST_RESET_ALERT = 8'b0000_1000,
    ST_HARD_RESET  = 8'b0001_0000,
    ST_SOFT_RESET  = 8'b0010_0000,
    ST_BRINGUP     = 8'b0100_0000,
    ST_OPERATIONAL = 8'b1000_0000
  } state_e;

  // Numeric state codes as seen on the result word.
  localparam logic [2:0] CODE_UNKNOWN     = 3'd0;
  localparam logic [2:0] CODE_DEAD        = 3'd1;
  localparam logic [2:0] CODE_BRINGDOWN   = 3'd2;
  localparam logic [2:0] CODE_RESET_ALERT = 3'd3;
  localparam logic [2:0] CODE_HARD_RESET  = 3'd4;
  localparam logic [2:0] CODE_SOFT_RESET  = 3'd5;
  localparam logic [2:0] CODE_BRINGUP     = 3'd6;
  localparam logic [2:0] CODE_OPERATIONAL = 3'd7;

  typedef enum logic [3:0] {
    ACT_NONE            = 4'd0,
    ACT_BRINGDOWN_ALERT = 4'd1,
    ACT_BRINGUP_INIT    = 4'd2,
    ACT_SOFT_RESET      = 4'd3,
    ACT_RESET_ALERT     = 4'd4,
    ACT_START_BIST      = 4'd5,
    ACT_DUMP_ALERT      = 4'd6,
    ACT_BRINGDOWN_DONE  = 4'd7,
    ACT_RESTORE_INIT    = 4'd8,
    ACT_RESTORE_SOFT    = 4'd9,
    ACT_IDENTIFY_HRRQ   = 4'd10,
    ACT_UNREGISTER      = 4'd11,
    ACT_MARK_DEAD       = 4'd12
  } action_e;

  typedef enum logic [2:0] {
    EV_NONE            = 3'd0,
    EV_SHUTDOWN_FAILED = 3'd1,
    EV_RESET_FAILED    = 3'd2,
    EV_SHUTDOWN_OK     = 3'd3,
    EV_RESET_OK        = 3'd4
  } event_e;

  typedef struct packed {
    logic       unit_check;
    logic       bringdown;
    logic [1:0] shutdown_kind;
    logic       enable_ok;
    logic       sticky_operational;
    logic       force_reset;
    logic       hard_reset;
    logic       mode;
  } item_t;

  typedef struct packed {
    state_e     state;
    logic [3:0] attempt;
    logic       busy;
    logic       bringdown;
    logic       unit_check;
    logic [1:0] shutdown_kind;
  } ctx_t;

  typedef struct packed {
    logic       in_progress;
    logic       register_hcams;
    logic       done;
    event_e     notify;
    action_e    action;
    logic [2:0] state_code;
  } result_t;

  function automatic logic [2:0] state_code(input state_e st);
    logic [2:0] code;
    case (st)
      ST_UNKNOWN:     code = CODE_UNKNOWN;
      ST_DEAD:        code = CODE_DEAD;
      ST_BRINGDOWN:   code = CODE_BRINGDOWN;
      ST_RESET_ALERT: code = CODE_RESET_ALERT;
      ST_HARD_RESET:  code = CODE_HARD_RESET;
      ST_SOFT_RESET:  code = CODE_SOFT_RESET;
      ST_BRINGUP:     code = CODE_BRINGUP;
      ST_OPERATIONAL: code = CODE_OPERATIONAL;
      default:        code = CODE_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

[hw/rtl/ars_step.sv]
// Next-state and result logic for one word of the reset engine.
`timescale 1ns / 1ps

module ars_step (
  input  ars_pkg::ctx_t    ctx_i,
  input  ars_pkg::item_t   item_i,
  input  logic [3:0]       max_attempts_i,
  output ars_pkg::ctx_t    ctx_o,
  output ars_pkg::result_t res_o
);

  logic [4:0] next_attempt;

  assign next_attempt = {1'b0, ctx_i.attempt} + 5'd1;

  always_comb begin
    ars_pkg::ctx_t    c;
    ars_pkg::action_e act;
    ars_pkg::event_e  ev;
    logic             done;
    logic             hcams;

    c     = ctx_i;
    act   = ars_pkg::ACT_NONE;
    ev    = ars_pkg::EV_NONE;
    done  = 1'b0;
    hcams = 1'b0;

    if (item_i.mode) begin
      // latch the request flags
      c.shutdown_kind = item_i.shutdown_kind;
      c.bringdown     = item_i.bringdown;
      c.unit_check    = item_i.unit_check;
    end else begin
      c.busy = 1'b1;
      case (ctx_i.state)
        ars_pkg::ST_DEAD: begin
          done = 1'b1;
        end
        ars_pkg::ST_BRINGDOWN: begin
          c.state = ars_pkg::ST_RESET_ALERT;
          act     = ars_pkg::ACT_BRINGDOWN_ALERT;
        end
        ars_pkg::ST_UNKNOWN: begin
          if (item_i.hard_reset) begin
            c.state = ars_pkg::ST_RESET_ALERT;
            act     = ars_pkg::ACT_RESET_ALERT;
          end else if (item_i.sticky_operational &
                       ars_pkg::STICKY_OPER_MASK) begin
            c.state = ars_pkg::ST_BRINGUP;
            act     = ars_pkg::ACT_BRINGUP_INIT;
          end else begin
            c.state = ars_pkg::ST_SOFT_RESET;
            act     = ars_pkg::ACT_SOFT_RESET;
          end
        end
        ars_pkg::ST_RESET_ALERT: begin
          c.state = ars_pkg::ST_HARD_RESET;
          act     = ars_pkg::ACT_START_BIST;
        end
        ars_pkg::ST_HARD_RESET: begin
          if (next_attempt > {1'b0, max_attempts_i}) begin
            c.attempt = '0;
            c.state   = ars_pkg::ST_DEAD;
            ev        = ctx_i.bringdown ? ars_pkg::EV_SHUTDOWN_FAILED
                                        : ars_pkg::EV_RESET_FAILED;
            act       = ars_pkg::ACT_MARK_DEAD;
            done      = 1'b1;
          end else if (ctx_i.unit_check) begin
            // unit check: retry without counting an attempt
            c.unit_check = 1'b0;
            c.state      = ars_pkg::ST_RESET_ALERT;
            act          = ars_pkg::ACT_DUMP_ALERT;
          end else begin
            c.attempt = next_attempt[3:0];
            if (ctx_i.bringdown) begin
              c.shutdown_kind = ars_pkg::SHUTDOWN_KIND_IDLE;
              c.bringdown     = 1'b0;
              c.state         = ars_pkg::ST_UNKNOWN;
              ev              = ars_pkg::EV_SHUTDOWN_OK;
              act             = ars_pkg::ACT_BRINGDOWN_DONE;
              done            = 1'b1;
            end else if (item_i.enable_ok) begin
              c.state = ars_pkg::ST_BRINGUP;
              act     = ars_pkg::ACT_RESTORE_INIT;
            end else begin
              c.state = ars_pkg::ST_SOFT_RESET;
              act     = ars_pkg::ACT_RESTORE_SOFT;
            end
          end
        end
        ars_pkg::ST_SOFT_RESET: begin
          c.state = ars_pkg::ST_BRINGUP;
          act     = ars_pkg::ACT_IDENTIFY_HRRQ;
        end
        ars_pkg::ST_BRINGUP: begin
          c.state = ars_pkg::ST_OPERATIONAL;
          done    = 1'b1;
        end
        ars_pkg::ST_OPERATIONAL: begin
          if (ctx_i.shutdown_kind == ars_pkg::SHUTDOWN_KIND_IDLE && !item_i.force_reset) begin
            ev   = ars_pkg::EV_RESET_OK;
            done = 1'b1;
          end else begin
            if (ctx_i.shutdown_kind != ars_pkg::SHUTDOWN_KIND_IDLE) begin
              c.state = ars_pkg::ST_BRINGDOWN;
            end
            act = ars_pkg::ACT_UNREGISTER;
          end
        end
        default: begin
          c.state = ars_pkg::ST_UNKNOWN;
        end
      endcase

      if (done) begin
        c.busy          = 1'b0;
        c.attempt       = '0;
        c.shutdown_kind = ars_pkg::SHUTDOWN_KIND_IDLE;
        c.bringdown     = 1'b0;
        hcams           = (c.state == ars_pkg::ST_OPERATIONAL);
      end
    end

    ctx_o                = c;
    res_o.state_code     = ars_pkg::state_code(c.state);
    res_o.action         = act;
    res_o.notify         = ev;
    res_o.done           = done;
    res_o.register_hcams = hcams;
    res_o.in_progress    = c.busy;
  end

endmodule

[hw/rtl/adapter_reset_sequencer.sv]
// Top level of the adapter reset sequencer: input register, engine state, result register.
//
// Usage:
//   Input words arrive on s_axis. tuser carries mode: 0 steps the reset
//   engine, 1 latches the shutdown, bringdown and unit-check requests
//   held in tdata. Every input word produces exactly one result word on
//   m_axis with the new engine state, the helper action to launch, the
//   notify event and the done, register-hcams and in-progress flags. max_attempts is
//   loaded via cfg_we_i / cfg_wdata_i; the user must do so only while idle, unchecked.
// Timing:
//   An accepted word lands in the input register; when the result register
//   is free or draining, the engine steps and the result register loads.
//   One word per cycle is sustained while m_axis_tready stays high: the
//   engine step is a single short combinational pass from the registered
//   state and the input register.
// Reset:
//   rst_ni clears the engine to unknown, the counter and all request
//   flags, empties both registers and restores max_attempts to 3.
// Stall:
//   While m_axis_tready is low the result word holds; the input register
//   still takes one more word, then s_axis_tready drops until the result
//   drains.
`timescale 1ns / 1ps

module adapter_reset_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: max_attempts
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] hard_reset, [1] force_reset, [2] sticky_operational, [3] enable_ok,
  // [5:4] new_shutdown_kind, [6] new_bringdown, [7] new_unit_check
  input  logic [7:0]  s_axis_tdata,
  // [0] mode
  input  logic        s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] engine_state_out, [6:3] action, [9:7] notify_event, [10] done_res,
  // [11] register_hcams, [12] in_progress, [15:13] zero
  output logic [15:0] m_axis_tdata
);

  logic [3:0]       max_attempts_q;
  logic             in_valid_q, in_valid_d;
  ars_pkg::item_t   item_q;
  logic             out_valid_q, out_valid_d;
  ars_pkg::result_t res_q;
  ars_pkg::ctx_t    ctx_q, ctx_d;
  ars_pkg::result_t res_d;
  logic             s_fire, m_fire, advance;

  // Step the engine whenever the input register holds a word and the
  // result register is free or draining this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_fire) begin
      out_valid_d = 1'b0;
    end
  end

  ars_step u_step (
    .ctx_i          (ctx_q),
    .item_i         (item_q),
    .max_attempts_i (max_attempts_q),
    .ctx_o          (ctx_d),
    .res_o          (res_d)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_attempts_q      <= 4'd3;
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
      ctx_q.state         <= ars_pkg::ST_UNKNOWN;
      ctx_q.attempt       <= '0;
      ctx_q.busy          <= 1'b0;
      ctx_q.bringdown     <= 1'b0;
      ctx_q.unit_check    <= 1'b0;
      ctx_q.shutdown_kind <= ars_pkg::SHUTDOWN_KIND_IDLE;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_attempts_q <= cfg_wdata_i;
      end
      if (advance) begin
        ctx_q <= ctx_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      item_q <= {s_axis_tdata, s_axis_tuser};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q};

  // Completion clears the sequence bookkeeping.
  a_done_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.done) |=> (!ctx_q.busy && ctx_q.attempt == 4'd0 &&
                                 !ctx_q.bringdown))
    else $error("completion left sequence state set");

  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(ctx_q.state))
    else $error("engine state lost one-hot encoding");

  a_hcams_oper : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.register_hcams) |->
      (res_q.done && res_q.state_code == ars_pkg::CODE_OPERATIONAL))
    else $error("hcams registered outside operational completion");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with an empty result register");

endmodule

[test/tb_adapter_reset_sequencer.sv]
// Self-checking testbench for the adapter reset sequencer: stream stimulus with a scoreboard.
`timescale 1ns / 1ps

module tb_adapter_reset_sequencer;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  // Tracks the engine state and attempt limit, and holds the result words still owed.
  class reset_engine_tracker;
    logic [2:0]       state_code_q;
    logic [3:0]       attempts;
    logic [3:0]       max_attempts;
    logic             busy;
    logic             bringdown;
    logic             unit_check;
    logic [1:0]       shutdown_kind;
    ars_pkg::result_t owed_results[$];
    int               errors;

    function new();
      state_code_q  = ars_pkg::CODE_UNKNOWN;
      attempts      = 4'd0;
      max_attempts  = 4'd3;
      busy          = 1'b0;
      bringdown     = 1'b0;
      unit_check    = 1'b0;
      shutdown_kind = ars_pkg::SHUTDOWN_KIND_IDLE;
      errors        = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Step the engine for one accepted word and queue the result it must produce.
    function void note_word(ars_pkg::item_t it);
      ars_pkg::result_t r;
      logic [4:0]       next_count;
      logic             done;
      r.action         = ars_pkg::ACT_NONE;
      r.notify         = ars_pkg::EV_NONE;
      r.register_hcams = 1'b0;
      done             = 1'b0;
      if (it.mode) begin
        shutdown_kind = it.shutdown_kind;
        bringdown     = it.bringdown;
        unit_check    = it.unit_check;
      end else begin
        busy = 1'b1;
        case (state_code_q)
          ars_pkg::CODE_DEAD: begin
            done = 1'b1;
          end
          ars_pkg::CODE_BRINGDOWN: begin
            state_code_q = ars_pkg::CODE_RESET_ALERT;
            r.action     = ars_pkg::ACT_BRINGDOWN_ALERT;
          end
          ars_pkg::CODE_UNKNOWN: begin
            if (it.hard_reset) begin
              state_code_q = ars_pkg::CODE_RESET_ALERT;
              r.action     = ars_pkg::ACT_RESET_ALERT;
            end else if (it.sticky_operational & ars_pkg::STICKY_OPER_MASK) begin
              state_code_q = ars_pkg::CODE_BRINGUP;
              r.action     = ars_pkg::ACT_BRINGUP_INIT;
            end else begin
              state_code_q = ars_pkg::CODE_SOFT_RESET;
              r.action     = ars_pkg::ACT_SOFT_RESET;
            end
          end
          ars_pkg::CODE_RESET_ALERT: begin
            state_code_q = ars_pkg::CODE_HARD_RESET;
            r.action     = ars_pkg::ACT_START_BIST;
          end
          ars_pkg::CODE_HARD_RESET: begin
            next_count = {1'b0, attempts} + 5'd1;
            if (next_count > {1'b0, max_attempts}) begin
              attempts     = 4'd0;
              state_code_q = ars_pkg::CODE_DEAD;
              if (bringdown) r.notify = ars_pkg::EV_SHUTDOWN_FAILED;
              else r.notify = ars_pkg::EV_RESET_FAILED;
              r.action = ars_pkg::ACT_MARK_DEAD;
              done     = 1'b1;
            end else if (unit_check) begin
              // a unit check sends the engine back without spending an attempt
              unit_check   = 1'b0;
              state_code_q = ars_pkg::CODE_RESET_ALERT;
              r.action     = ars_pkg::ACT_DUMP_ALERT;
            end else begin
              attempts = next_count[3:0];
              if (bringdown) begin
                shutdown_kind = ars_pkg::SHUTDOWN_KIND_IDLE;
                bringdown     = 1'b0;
                state_code_q  = ars_pkg::CODE_UNKNOWN;
                r.notify      = ars_pkg::EV_SHUTDOWN_OK;
                r.action      = ars_pkg::ACT_BRINGDOWN_DONE;
                done          = 1'b1;
              end else if (it.enable_ok) begin
                state_code_q = ars_pkg::CODE_BRINGUP;
                r.action     = ars_pkg::ACT_RESTORE_INIT;
              end else begin
                state_code_q = ars_pkg::CODE_SOFT_RESET;
                r.action     = ars_pkg::ACT_RESTORE_SOFT;
              end
            end
          end
          ars_pkg::CODE_SOFT_RESET: begin
            state_code_q = ars_pkg::CODE_BRINGUP;
            r.action     = ars_pkg::ACT_IDENTIFY_HRRQ;
          end
          ars_pkg::CODE_BRINGUP: begin
            state_code_q = ars_pkg::CODE_OPERATIONAL;
            done         = 1'b1;
          end
          default: begin
            if (shutdown_kind == ars_pkg::SHUTDOWN_KIND_IDLE && !it.force_reset) begin
              r.notify = ars_pkg::EV_RESET_OK;
              done     = 1'b1;
            end else begin
              // a forced reset with no shutdown stays operational
              if (shutdown_kind != ars_pkg::SHUTDOWN_KIND_IDLE) begin
                state_code_q = ars_pkg::CODE_BRINGDOWN;
              end
              r.action = ars_pkg::ACT_UNREGISTER;
            end
          end
        endcase
        if (done) begin
          busy          = 1'b0;
          attempts      = 4'd0;
          shutdown_kind = ars_pkg::SHUTDOWN_KIND_IDLE;
          bringdown     = 1'b0;
          r.register_hcams = (state_code_q == ars_pkg::CODE_OPERATIONAL);
        end
      end
      r.state_code  = state_code_q;
      r.done        = done;
      r.in_progress = busy;
      owed_results.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Match one accepted result word against the oldest owed result.
    function void check_word(logic [15:0] word);
      ars_pkg::result_t want;
      ars_pkg::result_t got;
      if (owed_results.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, actual %h", $time, word);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      got  = ars_pkg::result_t'(word[12:0]);
      compare_field("engine_state", want.state_code, got.state_code);
      compare_field("action", int'(want.action), int'(got.action));
      compare_field("notify_event", int'(want.notify), int'(got.notify));
      compare_field("done", want.done, got.done);
      compare_field("register_hcams", want.register_hcams, got.register_hcams);
      compare_field("in_progress", want.in_progress, got.in_progress);
      compare_field("pad", 0, word[15:13]);
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [3:0]  cfg_wdata_i   = 4'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  reset_engine_tracker engine = new();
  int unsigned cycles = 0;
  int unsigned stall_tick = 0;

  adapter_reset_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case a handshake never completes.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: check each accepted word, then pick the next ready level
  // from a pattern that moves between free flow and heavy stalling.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) engine.check_word(m_axis_tdata);
    stall_tick <= stall_tick + 1;
    case (stall_tick[8:7])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= ($urandom_range(0, 1) == 1);
      2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_tick[2:0] != 3'd7);
    endcase
  end

  function automatic ars_pkg::item_t step_item(logic hard, logic force_rst, logic sticky,
                                               logic enable);
    ars_pkg::item_t it;
    it                    = 9'($urandom);
    it.mode               = 1'b0;
    it.hard_reset         = hard;
    it.force_reset        = force_rst;
    it.sticky_operational = sticky;
    it.enable_ok          = enable;
    return it;
  endfunction

  function automatic ars_pkg::item_t latch_item(logic [1:0] kind, logic bd, logic uc);
    ars_pkg::item_t it;
    it               = 9'($urandom);
    it.mode          = 1'b1;
    it.shutdown_kind = kind;
    it.bringdown     = bd;
    it.unit_check    = uc;
    return it;
  endfunction

  // Hold the word until accepted; tvalid stays high so a burst can follow.
  task automatic push_word(ars_pkg::item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.mode;
    s_axis_tdata  <= it[8:1];
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    engine.note_word(it);
  endtask

  // Drop tvalid and wait for every owed result to drain.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (engine.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_max_attempts(logic [3:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    engine.max_attempts = value;
  endtask

  // Random words in bursts; mostly engine steps, some request latches.
  task automatic run_random(int count, bit pause_midway);
    int             burst;
    int             gap;
    ars_pkg::item_t it;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < count; i++) begin
      it      = 9'($urandom);
      it.mode = ($urandom_range(0, 6) == 0);
      push_word(it);
      if (pause_midway && i == count / 2) drain();
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk with the default limit of three attempts.
    push_word(latch_item(2'd0, 1'b0, 1'b0));
    push_word(step_item(1'b0, 1'b0, 1'b1, 1'b0));  // unknown, sticky set: bringup
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b0));  // bringup: operational, done
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b0));  // operational, nothing pending: reset ok
    push_word(step_item(1'b0, 1'b1, 1'b0, 1'b0));  // forced reset, no shutdown
    push_word(latch_item(2'd3, 1'b1, 1'b1));
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b0));  // operational: bringdown
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b0));  // bringdown: reset alert
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b0));  // reset alert: hard reset
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b1));  // unit check: dump, back to alert
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b0));
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b1));  // bringdown done: unknown, shutdown ok
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b0));  // unknown, no sticky: soft reset
    push_word(step_item(1'b1, 1'b1, 1'b1, 1'b1));  // soft reset: bringup
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b0));
    push_word(latch_item(2'd2, 1'b0, 1'b0));
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b0));
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b0));
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b0));
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b0));  // hard reset, enable failed: soft
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b0));
    push_word(step_item(1'b0, 1'b0, 1'b0, 1'b0));
    drain();

    run_random(190, 1'b0);
    write_max_attempts(4'd1);
    run_random(220, 1'b0);
    write_max_attempts(4'd14);
    run_random(220, 1'b1);
    write_max_attempts(4'd15);
    run_random(220, 1'b0);
    write_max_attempts(4'd7);
    run_random(220, 1'b0);

    // Zero attempts: the first hard reset step marks the adapter dead for good.
    write_max_attempts(4'd0);
    run_random(80, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (engine.pending() != 0) begin
      $display("%0t ns: results missing, expected %0d more, actual 0",
               $time, engine.pending());
      engine.errors++;
    end
    if (engine.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/ars_pkg.sv
hw/rtl/ars_step.sv
hw/rtl/adapter_reset_sequencer.sv
test/tb_adapter_reset_sequencer.sv
